FILE: rtl/coning_delta_angle_integrator_assert.svh
// Assertion macros for the coning delta-angle integrator.
// Expects aclk and aresetn in the scope of use.
`ifndef CONING_DELTA_ANGLE_INTEGRATOR_ASSERT_SVH
`define CONING_DELTA_ANGLE_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define CDAI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDAI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cdai_pkg.sv
// Shared widths, codes, state encoding and saturation helpers
// for the coning delta-angle integrator. No dependencies.
package cdai_pkg;

    localparam int RATE_W   = 24;
    localparam int SUM_W    = RATE_W + 1;
    localparam int ANGLE_W  = 32;
    localparam int DT_W     = 32;
    localparam int STAMP_W  = 64;
    localparam int FB_W     = 20;
    localparam int STALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 64;
    localparam int DVSR_W   = 14;
    localparam int MUL_CNT_W = 6;
    localparam int DIV_CNT_W = 7;
    localparam int DIFF_W   = PROD_W + 1;
    localparam int CONE_W   = 35;
    localparam int UPD_W    = CONE_W + 1;
    localparam int IN_W     = 3 * RATE_W + 2 * STAMP_W;
    localparam int OUT_W    = 3 * ANGLE_W + DT_W;
    localparam int NUM_MUL  = 6;

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(MUL_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    localparam logic [FB_W-1:0]    FALLBACK_REJECT_US = FB_W'(10000);
    localparam logic [FB_W-1:0]    FALLBACK_RESET     = FB_W'(1000);
    localparam logic [STALE_W-1:0] STALE_RESET        = STALE_W'(100000);
    localparam logic [DVSR_W-1:0]  DELTA_DVSR         = DVSR_W'(15625);
    localparam logic [DVSR_W-1:0]  SIXTH_DVSR         = DVSR_W'(6);
    localparam logic [DIV_W-1:0]   DELTA_BIAS         = DIV_W'(7812);
    localparam logic [ANGLE_W-1:0] SIXTH_BIAS         = ANGLE_W'(3);
    localparam logic [DIFF_W-1:0]  CONE_BIAS          = DIFF_W'(1) << 29;
    localparam int                 CONE_SHIFT         = 30;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_PUBLISH = 1'b1
    } op_t;

    typedef enum logic {
        CFG_FALLBACK = 1'b0,
        CFG_STALE    = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH_A,
        ST_RUN_A,
        ST_BASE,
        ST_RUN_B,
        ST_DELTA,
        ST_LAUNCH_C,
        ST_RUN_C,
        ST_SIGN,
        ST_DIFF,
        ST_MAG,
        ST_UPDATE,
        ST_DONE
    } state_t;

    function automatic logic [ANGLE_W-1:0] sat33(input logic [ANGLE_W:0] v);
        logic [ANGLE_W-1:0] r;
        if (v[ANGLE_W] != v[ANGLE_W-1]) begin
            r = v[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ANGLE_W-1:0] sat36(input logic [UPD_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        logic               hi_ok;
        hi_ok = (v[UPD_W-1:ANGLE_W-1] == '0) || (v[UPD_W-1:ANGLE_W-1] == '1);
        if (!hi_ok) begin
            r = v[UPD_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/cdai_smul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on cdai_pkg.
module cdai_smul import cdai_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_W-1:0]     a_reg, hi_reg, lo_reg;
    logic [MUL_W:0]       sum;

    always_comb begin
        sum = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? a_reg : '0)};
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = MUL_STEPS;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (cnt_reg != '0) begin
            hi_reg <= sum[MUL_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign done = (cnt_reg == '0);
    assign prod = {hi_reg, lo_reg};

endmodule

FILE: rtl/cdai_sdiv.sv
// Bit-serial restoring divider by a narrow divisor, one quotient bit per cycle.
// Depends on cdai_pkg.
module cdai_sdiv import cdai_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quot
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0]    dvsr_reg, rem_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DVSR_W:0]      trial, sub;
    logic                 ge;

    always_comb begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        sub   = trial - {1'b0, dvsr_reg};
        ge    = (trial >= {1'b0, dvsr_reg});
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = DIV_STEPS;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvsr_reg <= divisor;
            rem_reg  <= '0;
            quot_reg <= dividend;
        end else if (cnt_reg != '0) begin
            rem_reg  <= ge ? sub[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
        end
    end

    assign done = (cnt_reg == '0);
    assign quot = quot_reg;

endmodule

FILE: rtl/coning_delta_angle_integrator.sv
// Coning-corrected delta-angle integrator, top level with sequencer and datapath.
// Depends on cdai_pkg, cdai_smul, cdai_sdiv and the assertion macro header.
//
// Usage:
//   s_ channel: one beat per item. s_tuser selects gyro sample (0) or publish (1);
//   s_tdata carries the three rates and the two 64-bit times.
//   m_ channel: exactly one result beat per input beat, in order.
//   Configuration: cfg_wr_en/cfg_index/cfg_data, written while idle.
// Sequencing:
//   A publish or rejected sample goes from preparation straight to the output;
//   an integrated sample runs two 64-step serial division passes (the sixth
//   of the previous delta, alongside a 32-step rate*dt multiply, then rate*dt
//   scaling) and one 32-step serial multiply pass for the coning cross product.
//   One item is processed at a time; s_tready is high while the sequencer idles.
// Reset: synchronous, active low; clears the accumulator, history and
//   configuration to their defaults, and drops any pending result.
// Stall: a finished result waits in the output register; the next item is
//   accepted and processed meanwhile and holds at completion until the
//   output register frees.
`include "coning_delta_angle_integrator_assert.svh"

module coning_delta_angle_integrator import cdai_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // rate_x, rate_y, rate_z, stamp_us, now_us
    input  logic [0:0]        s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // angle_x, angle_y, angle_z, angle_dt_us
    output logic [1:0]        m_tuser,   // accepted, valid_res
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [FB_W-1:0]    fb_reg;
    logic [STALE_W-1:0] stale_reg;

    logic [ANGLE_W-1:0] acc_reg    [3];
    logic [DT_W-1:0]    acc_dt_reg;
    logic [ANGLE_W-1:0] pdelta_reg [3];
    logic [RATE_W-1:0]  prate_reg  [3];
    logic [STAMP_W-1:0] last_stamp_reg;
    logic               fresh_reg;

    op_t                op_reg;
    logic [RATE_W-1:0]  rate_reg [3];
    logic [STAMP_W-1:0] stamp_reg, now_reg, new_stamp_reg;
    logic [DT_W-1:0]    dt_reg;
    logic               stale_hit_reg;
    logic [SUM_W-1:0]   s_mag_reg [3];
    logic               s_neg_reg [3];
    logic [ANGLE_W-1:0] sixth_arg_reg [3];
    logic               pd_neg_reg [3];
    logic [ANGLE_W-1:0] base_reg  [3];
    logic [ANGLE_W-1:0] delta_reg [3];
    logic               psign_reg [NUM_MUL];
    logic [DIFF_W-1:0]  pv_reg    [NUM_MUL];
    logic [DIFF_W-1:0]  diff_reg  [3];
    logic [CONE_W-1:0]  cmag_reg  [3];
    logic               cneg_reg  [3];

    logic [1:0]         res_user_reg;
    logic [OUT_W-1:0]   res_data_reg;
    logic               m_tvalid_reg;
    logic [1:0]         m_tuser_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic mul_start_a, mul_start_c, div_start, div_sel_b, out_load;

    logic [MUL_W-1:0]  mul_a    [NUM_MUL];
    logic [MUL_W-1:0]  mul_b    [NUM_MUL];
    logic [PROD_W-1:0] mul_prod [NUM_MUL];
    logic              mul_done [NUM_MUL];
    logic [DIV_W-1:0]  div_arg  [3];
    logic [DIV_W-1:0]  div_quot [3];
    logic              div_done [3];
    logic              mul_all_done, div_all_done;

    // prep-stage values
    logic [STAMP_W-1:0] stamp_gap, now_gap;
    logic               use_ts, reject;
    logic [DT_W-1:0]    dt_sel;
    logic [SUM_W-1:0]   rsum [3];

    // cross-product operand magnitudes
    logic [ANGLE_W-1:0] bmag [3], dmag [3];

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    always_comb begin
        bmag[0] = base_reg[0][ANGLE_W-1] ? -base_reg[0] : base_reg[0];
        bmag[1] = base_reg[1][ANGLE_W-1] ? -base_reg[1] : base_reg[1];
        bmag[2] = base_reg[2][ANGLE_W-1] ? -base_reg[2] : base_reg[2];
        dmag[0] = delta_reg[0][ANGLE_W-1] ? -delta_reg[0] : delta_reg[0];
        dmag[1] = delta_reg[1][ANGLE_W-1] ? -delta_reg[1] : delta_reg[1];
        dmag[2] = delta_reg[2][ANGLE_W-1] ? -delta_reg[2] : delta_reg[2];

        // x: b1*d2 - b2*d1, y: b2*d0 - b0*d2, z: b0*d1 - b1*d0
        for (int i = 0; i < 3; i++) begin
            mul_a[i] = mul_start_c ? bmag[(i + 1) % 3]
                                   : {{(MUL_W-SUM_W){1'b0}}, s_mag_reg[i]};
            mul_b[i] = mul_start_c ? dmag[(i + 2) % 3] : dt_reg;
            mul_a[i + 3] = bmag[(i + 2) % 3];
            mul_b[i + 3] = dmag[(i + 1) % 3];
        end

        for (int i = 0; i < 3; i++) begin
            div_arg[i] = div_sel_b ? ({mul_prod[i][DIV_W-7:0], 6'b0} + DELTA_BIAS)
                                   : {{(DIV_W-ANGLE_W){1'b0}}, sixth_arg_reg[i]};
        end

        mul_all_done = 1'b1;
        for (int k = 0; k < NUM_MUL; k++) begin
            mul_all_done = mul_all_done & mul_done[k];
        end
        div_all_done = div_done[0] & div_done[1] & div_done[2];
    end

    for (genvar k = 0; k < NUM_MUL; k++) begin : g_mul
        cdai_smul u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   ((k < 3) ? (mul_start_a | mul_start_c) : mul_start_c),
            .a       (mul_a[k]),
            .b       (mul_b[k]),
            .done    (mul_done[k]),
            .prod    (mul_prod[k])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        cdai_sdiv u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (div_arg[i]),
            .divisor  (div_sel_b ? DELTA_DVSR : SIXTH_DVSR),
            .done     (div_done[i]),
            .quot     (div_quot[i])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        stamp_gap = stamp_reg - last_stamp_reg;
        now_gap   = now_reg - last_stamp_reg;
        use_ts    = (stamp_reg != '0) && (last_stamp_reg != '0);
        reject    = !use_ts && (fb_reg > FALLBACK_REJECT_US);
        if (use_ts) begin
            dt_sel = (stamp_gap[STAMP_W-1:DT_W] != '0) ? '1 : stamp_gap[DT_W-1:0];
        end else begin
            dt_sel = {{(DT_W-FB_W){1'b0}}, fb_reg};
        end
        for (int i = 0; i < 3; i++) begin
            rsum[i] = {rate_reg[i][RATE_W-1], rate_reg[i]}
                    + {prate_reg[i][RATE_W-1], prate_reg[i]};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_PREP;
            ST_PREP: begin
                if (op_reg == OP_PUBLISH || reject) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LAUNCH_A;
                end
            end
            ST_LAUNCH_A: state_next = ST_RUN_A;
            ST_RUN_A:    if (mul_all_done && div_all_done) state_next = ST_BASE;
            ST_BASE:     state_next = ST_RUN_B;
            ST_RUN_B:    if (div_all_done) state_next = ST_DELTA;
            ST_DELTA:    state_next = ST_LAUNCH_C;
            ST_LAUNCH_C: state_next = ST_RUN_C;
            ST_RUN_C:    if (mul_all_done) state_next = ST_SIGN;
            ST_SIGN:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_MAG;
            ST_MAG:      state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_DONE;
            ST_DONE:     if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        mul_start_a = 1'b0;
        mul_start_c = 1'b0;
        div_start   = 1'b0;
        div_sel_b   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready = 1'b1;
            ST_LAUNCH_A: begin
                mul_start_a = 1'b1;
                div_start   = 1'b1;
            end
            ST_BASE: begin
                div_start = 1'b1;
                div_sel_b = 1'b1;
            end
            ST_LAUNCH_C: mul_start_c = 1'b1;
            ST_DONE:     out_load = !m_tvalid_reg || m_tready;
            default:     s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and integrator state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg    <= FALLBACK_RESET;
            stale_reg <= STALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FALLBACK: fb_reg    <= cfg_data[FB_W-1:0];
                CFG_STALE:    stale_reg <= cfg_data[STALE_W-1:0];
                default:      fb_reg    <= fb_reg;
            endcase
        end
    end

    logic [UPD_W-1:0] cone_v [3];
    logic [UPD_W-1:0] upd_sum [3];
    logic [DT_W:0]    dt_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cone_v[i] = cneg_reg[i] ? -{1'b0, cmag_reg[i]} : {1'b0, cmag_reg[i]};
            upd_sum[i] = cone_v[i];
            if (!stale_hit_reg) begin
                upd_sum[i] = cone_v[i]
                           + {{(UPD_W-ANGLE_W){acc_reg[i][ANGLE_W-1]}}, acc_reg[i]}
                           + {{(UPD_W-ANGLE_W){delta_reg[i][ANGLE_W-1]}}, delta_reg[i]};
            end
        end
        dt_sum = {1'b0, acc_dt_reg} + {1'b0, dt_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i]    <= '0;
                pdelta_reg[i] <= '0;
                prate_reg[i]  <= '0;
            end
            acc_dt_reg     <= '0;
            last_stamp_reg <= '0;
            fresh_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_PREP: begin
                    if (op_reg == OP_PUBLISH) begin
                        for (int i = 0; i < 3; i++) begin
                            acc_reg[i] <= '0;
                        end
                        acc_dt_reg <= '0;
                        fresh_reg  <= 1'b0;
                    end
                end
                ST_UPDATE: begin
                    for (int i = 0; i < 3; i++) begin
                        acc_reg[i]    <= sat36(upd_sum[i]);
                        pdelta_reg[i] <= stale_hit_reg ? '0 : delta_reg[i];
                        prate_reg[i]  <= rate_reg[i];
                    end
                    if (stale_hit_reg) begin
                        acc_dt_reg <= '0;
                    end else begin
                        acc_dt_reg <= dt_sum[DT_W] ? '1 : dt_sum[DT_W-1:0];
                    end
                    last_stamp_reg <= new_stamp_reg;
                    fresh_reg      <= 1'b1;
                end
                default: fresh_reg <= fresh_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-item datapath
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0] diff_abs [3];
    logic [DIFF_W-1:0] cone_r   [3];
    logic [ANGLE_W:0]  six_v    [3];
    logic [ANGLE_W-1:0] pd_abs  [3];
    logic              q_big    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_abs[i] = diff_reg[i][DIFF_W-1] ? -diff_reg[i] : diff_reg[i];
            cone_r[i]   = (diff_abs[i] + CONE_BIAS) >> CONE_SHIFT;
            six_v[i]    = pd_neg_reg[i] ? -{1'b0, div_quot[i][ANGLE_W-1:0]}
                                        : {1'b0, div_quot[i][ANGLE_W-1:0]};
            pd_abs[i]   = pdelta_reg[i][ANGLE_W-1] ? -pdelta_reg[i] : pdelta_reg[i];
            q_big[i]    = (div_quot[i][DIV_W-1:ANGLE_W-1] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg      <= op_t'(s_tuser[0]);
            rate_reg[0] <= s_tdata[RATE_W-1:0];
            rate_reg[1] <= s_tdata[2*RATE_W-1:RATE_W];
            rate_reg[2] <= s_tdata[3*RATE_W-1:2*RATE_W];
            stamp_reg   <= s_tdata[3*RATE_W+STAMP_W-1:3*RATE_W];
            now_reg     <= s_tdata[IN_W-1:3*RATE_W+STAMP_W];
        end
        case (state_reg)
            ST_PREP: begin
                res_user_reg <= (op_reg == OP_PUBLISH && fresh_reg) ? 2'b10 : 2'b00;
                res_data_reg <= (op_reg == OP_PUBLISH && fresh_reg)
                              ? {acc_dt_reg, acc_reg[2], acc_reg[1], acc_reg[0]} : '0;
                dt_reg        <= dt_sel;
                new_stamp_reg <= use_ts ? stamp_reg : now_reg;
                for (int i = 0; i < 3; i++) begin
                    s_neg_reg[i]     <= rsum[i][SUM_W-1];
                    s_mag_reg[i]     <= rsum[i][SUM_W-1] ? -rsum[i] : rsum[i];
                    pd_neg_reg[i]    <= pdelta_reg[i][ANGLE_W-1];
                    sixth_arg_reg[i] <= pd_abs[i] + SIXTH_BIAS;
                end
            end
            ST_LAUNCH_A: begin
                stale_hit_reg <= (now_gap > {{(STAMP_W-STALE_W){1'b0}}, stale_reg});
            end
            ST_BASE: begin
                for (int i = 0; i < 3; i++) begin
                    base_reg[i] <= sat33({acc_reg[i][ANGLE_W-1], acc_reg[i]} + six_v[i]);
                end
            end
            ST_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    if (s_neg_reg[i]) begin
                        delta_reg[i] <= q_big[i] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                                 : -div_quot[i][ANGLE_W-1:0];
                    end else begin
                        delta_reg[i] <= q_big[i] ? {1'b0, {(ANGLE_W-1){1'b1}}}
                                                 : div_quot[i][ANGLE_W-1:0];
                    end
                end
            end
            ST_LAUNCH_C: begin
                for (int i = 0; i < 3; i++) begin
                    psign_reg[i]     <= base_reg[(i + 1) % 3][ANGLE_W-1]
                                      ^ delta_reg[(i + 2) % 3][ANGLE_W-1];
                    psign_reg[i + 3] <= base_reg[(i + 2) % 3][ANGLE_W-1]
                                      ^ delta_reg[(i + 1) % 3][ANGLE_W-1];
                end
            end
            ST_SIGN: begin
                for (int k = 0; k < NUM_MUL; k++) begin
                    pv_reg[k] <= psign_reg[k] ? -{1'b0, mul_prod[k]} : {1'b0, mul_prod[k]};
                end
            end
            ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    diff_reg[i] <= pv_reg[i] - pv_reg[i + 3];
                end
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    cneg_reg[i] <= diff_reg[i][DIFF_W-1];
                    cmag_reg[i] <= cone_r[i][CONE_W-1:0];
                end
            end
            ST_UPDATE: begin
                res_user_reg <= 2'b01;
                res_data_reg <= '0;
            end
            default: res_user_reg <= res_user_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_user_reg;
            m_tdata_reg <= res_data_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CDAI_ASSERT_NOW(a_sample_beat_no_angles, m_tvalid && m_tuser[0], m_tdata == '0, "sample beat carries angle data")
    `CDAI_ASSERT_NEXT(a_publish_clears, state_reg == ST_PREP && op_reg == OP_PUBLISH, !fresh_reg && acc_dt_reg == '0 && state_reg == ST_DONE, "publish did not clear accumulator")
    `CDAI_ASSERT_NEXT(a_update_sets_fresh, state_reg == ST_UPDATE, fresh_reg && state_reg == ST_DONE, "integration did not mark fresh data")

endmodule
